@@ src/scu_pkg.sv @@
package scu_pkg;

    localparam int FRAC_T      = 30;
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = FRAC_T + 1;
    localparam int CFG_IDX_W   = 1;

    localparam logic [31:0] CORR_Q32 = 32'd4291276798;

    localparam logic [CFG_IDX_W-1:0] CFG_INV_H = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORM  = 1'b1;

    localparam logic [31:0] INV_H_RST = 32'd65536;
    localparam logic [31:0] NORM_RST  = 32'd7450;

    typedef struct packed {
        logic signed [31:0] dx;
        logic signed [31:0] dy;
    } item_t;

    typedef struct packed {
        logic        [31:0] dist_norm;
        logic signed [31:0] weight;
        logic signed [31:0] grad_x;
        logic signed [31:0] grad_y;
        logic               zero_dist;
    } result_t;

    typedef struct packed {
        logic [31:0] xm;
        logic [31:0] ym;
        logic        xneg;
        logic        yneg;
    } sqrt_side_t;

    typedef struct packed {
        logic [63:0] p;
        logic [34:0] gmag;
        logic        gneg;
        logic        xneg;
        logic        yneg;
    } div_side_t;

endpackage

@@ src/scu_sqrt_pipe.sv @@
module scu_sqrt_pipe
    import scu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [63:0] radicand,
    input  sqrt_side_t  side_in,
    output logic        out_valid,
    output logic [31:0] root,
    output sqrt_side_t  side_out
);

    logic        valid_reg [SQRT_STAGES];
    logic [63:0] rem_reg   [SQRT_STAGES];
    logic [63:0] res_reg   [SQRT_STAGES];
    sqrt_side_t  side_reg  [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_stage
        localparam int SH = 2 * (SQRT_STAGES - 1 - k);
        logic        vin;
        logic [63:0] rem_in;
        logic [63:0] res_in;
        sqrt_side_t  sd_in;
        logic [63:0] trial;
        logic [63:0] rem_next;
        logic [63:0] res_next;

        if (k == 0)
        begin : g_first
            assign vin    = in_valid;
            assign rem_in = radicand;
            assign res_in = 64'd0;
            assign sd_in  = side_in;
        end
        else
        begin : g_rest
            assign vin    = valid_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign res_in = res_reg[k-1];
            assign sd_in  = side_reg[k-1];
        end

        assign trial = res_in + (64'd1 << SH);

        always_comb
        begin
            if (rem_in >= trial)
            begin
                rem_next = rem_in - trial;
                res_next = (res_in >> 1) + (64'd1 << SH);
            end
            else
            begin
                rem_next = rem_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= vin;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            res_reg[k]  <= res_next;
            side_reg[k] <= sd_in;
        end
    end

    assign out_valid = valid_reg[SQRT_STAGES-1];
    assign root      = res_reg[SQRT_STAGES-1][31:0];
    assign side_out  = side_reg[SQRT_STAGES-1];

endmodule

@@ src/scu_div_pipe.sv @@
module scu_div_pipe
    import scu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [31:0]           divisor,
    input  logic [31:0]           num_x,
    input  logic [31:0]           num_y,
    input  div_side_t             side_in,
    output logic                  out_valid,
    output logic [31:0]           divisor_out,
    output logic [DIV_STAGES-1:0] quo_x,
    output logic [DIV_STAGES-1:0] quo_y,
    output div_side_t             side_out
);

    localparam int REM_W = 33 + FRAC_T;

    logic                  valid_reg [DIV_STAGES];
    logic [31:0]           dvs_reg   [DIV_STAGES];
    logic [REM_W-1:0]      remx_reg  [DIV_STAGES];
    logic [REM_W-1:0]      remy_reg  [DIV_STAGES];
    logic [DIV_STAGES-1:0] qx_reg    [DIV_STAGES];
    logic [DIV_STAGES-1:0] qy_reg    [DIV_STAGES];
    div_side_t             side_reg  [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_stage
        localparam int SH = DIV_STAGES - 1 - j;
        logic                  vin;
        logic [31:0]           dvs_in;
        logic [REM_W-1:0]      remx_in;
        logic [REM_W-1:0]      remy_in;
        logic [DIV_STAGES-1:0] qx_in;
        logic [DIV_STAGES-1:0] qy_in;
        div_side_t             sd_in;
        logic [REM_W-1:0]      sub;
        logic [REM_W-1:0]      remx_next;
        logic [REM_W-1:0]      remy_next;
        logic [DIV_STAGES-1:0] qx_next;
        logic [DIV_STAGES-1:0] qy_next;

        if (j == 0)
        begin : g_first
            assign vin     = in_valid;
            assign dvs_in  = divisor;
            assign remx_in = {1'b0, num_x, {FRAC_T{1'b0}}};
            assign remy_in = {1'b0, num_y, {FRAC_T{1'b0}}};
            assign qx_in   = '0;
            assign qy_in   = '0;
            assign sd_in   = side_in;
        end
        else
        begin : g_rest
            assign vin     = valid_reg[j-1];
            assign dvs_in  = dvs_reg[j-1];
            assign remx_in = remx_reg[j-1];
            assign remy_in = remy_reg[j-1];
            assign qx_in   = qx_reg[j-1];
            assign qy_in   = qy_reg[j-1];
            assign sd_in   = side_reg[j-1];
        end

        assign sub = REM_W'(dvs_in) << SH;

        always_comb
        begin
            remx_next = remx_in;
            qx_next   = qx_in;
            remy_next = remy_in;
            qy_next   = qy_in;
            if (remx_in >= sub)
            begin
                remx_next = remx_in - sub;
                qx_next   = qx_in | (DIV_STAGES'(1) << SH);
            end
            if (remy_in >= sub)
            begin
                remy_next = remy_in - sub;
                qy_next   = qy_in | (DIV_STAGES'(1) << SH);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else
            begin
                valid_reg[j] <= vin;
            end
        end

        always_ff @(posedge clk)
        begin
            dvs_reg[j]  <= dvs_in;
            remx_reg[j] <= remx_next;
            remy_reg[j] <= remy_next;
            qx_reg[j]   <= qx_next;
            qy_reg[j]   <= qy_next;
            side_reg[j] <= sd_in;
        end
    end

    assign out_valid   = valid_reg[DIV_STAGES-1];
    assign divisor_out = dvs_reg[DIV_STAGES-1];
    assign quo_x       = qx_reg[DIV_STAGES-1];
    assign quo_y       = qy_reg[DIV_STAGES-1];
    assign side_out    = side_reg[DIV_STAGES-1];

endmodule

@@ src/sph_cubic_kernel_gradient_unit.sv @@
// Channel   Signals                        Transaction
// command   start, busy, item              start high while busy low
// result    done, result                   done high for one cycle
// config    cfg_we, cfg_index, cfg_data    cfg_we high
//
// One transaction enters per cycle; busy never rises.
// The pipeline has 3 input/square stages, 32 square-root stages,
// 5 kernel-polynomial stages, 31 divider stages and 3 output multiply stages.
// Reset clears the valid bits and loads the configuration defaults.
// There is no stall: each result is shown once, in its own cycle.
module sph_cubic_kernel_gradient_unit
    import scu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  item_t                item,
    output logic                 done,
    output result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int LATENCY = 3 + SQRT_STAGES + 5 + DIV_STAGES + 3;

    logic [31:0] inv_reg;
    logic [31:0] norm_reg;
    logic [31:0] ac_reg;
    logic [63:0] m_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg  <= INV_H_RST;
            norm_reg <= NORM_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_INV_H: inv_reg  <= cfg_data;
                CFG_NORM:  norm_reg <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        ac_reg <= 32'((64'(norm_reg) * 64'(CORR_Q32)) >> 32);
        m_reg  <= 64'(norm_reg) * 64'(inv_reg);
    end

    assign busy = 1'b0;

    // input, magnitudes, squares
    logic        v1_reg, v2_reg, v3_reg;
    sqrt_side_t  s1_reg, s2_reg, s3_reg;
    logic [63:0] xx_reg, yy_reg, sq_reg;
    sqrt_side_t  s1_next;

    always_comb
    begin
        s1_next.xneg = item.dx[31];
        s1_next.yneg = item.dy[31];
        s1_next.xm   = item.dx[31] ? (~item.dx + 32'd1) : item.dx;
        s1_next.ym   = item.dy[31] ? (~item.dy + 32'd1) : item.dy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
        xx_reg <= 64'(s1_reg.xm) * 64'(s1_reg.xm);
        yy_reg <= 64'(s1_reg.ym) * 64'(s1_reg.ym);
        s2_reg <= s1_reg;
        sq_reg <= xx_reg + yy_reg;
        s3_reg <= s2_reg;
    end

    logic        sq_valid;
    logic [31:0] root;
    sqrt_side_t  sq_side;

    scu_sqrt_pipe u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .radicand  (sq_reg),
        .side_in   (s3_reg),
        .out_valid (sq_valid),
        .root      (root),
        .side_out  (sq_side)
    );

    // kernel polynomial
    logic               p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    sqrt_side_t         k1_reg, k2_reg, k3_reg, k4_reg, k5_reg;
    logic [31:0]        r1_reg, r2_reg, r3_reg, r4_reg, r5_reg;
    logic [63:0]        q_reg;
    logic [30:0]        t1_reg, t1b_reg;
    logic [31:0]        t2_reg, t2b_reg;
    logic [30:0]        t1s_reg;
    logic [32:0]        t2s_reg;
    logic [61:0]        t1c_reg;
    logic [63:0]        t2c_reg;
    logic signed [36:0] g_reg;
    logic [63:0]        p_reg;
    logic [34:0]        gmag_reg;
    logic               gneg_reg;
    logic [63:0]        one_m_q, two_m_q;
    logic [61:0]        t1sq;
    logic [63:0]        t2sq;
    logic [64:0]        t2c_full;
    logic [63:0]        four_t1c;

    assign one_m_q  = (q_reg < (64'd1 << 32)) ? ((64'd1 << 32) - q_reg) : 64'd0;
    assign two_m_q  = (q_reg < (64'd1 << 33)) ? ((64'd1 << 33) - q_reg) : 64'd0;
    assign t1sq     = 62'(t1_reg) * 62'(t1_reg);
    assign t2sq     = 64'(t2_reg) * 64'(t2_reg);
    assign t2c_full = 65'(t2s_reg) * 65'(t2b_reg);
    assign four_t1c = 64'(t1c_reg) << 2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg <= 1'b0;
            p2_reg <= 1'b0;
            p3_reg <= 1'b0;
            p4_reg <= 1'b0;
            p5_reg <= 1'b0;
        end
        else
        begin
            p1_reg <= sq_valid;
            p2_reg <= p1_reg;
            p3_reg <= p2_reg;
            p4_reg <= p3_reg;
            p5_reg <= p4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg    <= 64'(root) * 64'(inv_reg);
        r1_reg   <= root;
        k1_reg   <= sq_side;

        t1_reg   <= one_m_q[32:2];
        t2_reg   <= two_m_q[33:2];
        r2_reg   <= r1_reg;
        k2_reg   <= k1_reg;

        t1s_reg  <= t1sq[60:30];
        t2s_reg  <= t2sq[62:30];
        t1b_reg  <= t1_reg;
        t2b_reg  <= t2_reg;
        r3_reg   <= r2_reg;
        k3_reg   <= k2_reg;

        t1c_reg  <= 62'(t1s_reg) * 62'(t1b_reg);
        t2c_reg  <= t2c_full[63:0];
        g_reg    <= $signed(37'(t1s_reg) * 37'd12) - $signed(37'(t2s_reg) * 37'd3);
        r4_reg   <= r3_reg;
        k4_reg   <= k3_reg;

        p_reg    <= (four_t1c > t2c_reg) ? 64'd0 : (t2c_reg - four_t1c);
        gneg_reg <= g_reg[36];
        gmag_reg <= g_reg[36] ? 35'(-g_reg) : 35'(g_reg);
        r5_reg   <= r4_reg;
        k5_reg   <= k4_reg;
    end

    div_side_t dv_side_in;

    always_comb
    begin
        dv_side_in.p    = p_reg;
        dv_side_in.gmag = gmag_reg;
        dv_side_in.gneg = gneg_reg;
        dv_side_in.xneg = k5_reg.xneg;
        dv_side_in.yneg = k5_reg.yneg;
    end

    logic                  dv_valid;
    logic [31:0]           dv_r;
    logic [DIV_STAGES-1:0] ux, uy;
    div_side_t             dv_side;

    scu_div_pipe u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (p5_reg),
        .divisor     (r5_reg),
        .num_x       (k5_reg.xm),
        .num_y       (k5_reg.ym),
        .side_in     (dv_side_in),
        .out_valid   (dv_valid),
        .divisor_out (dv_r),
        .quo_x       (ux),
        .quo_y       (uy),
        .side_out    (dv_side)
    );

    // output multiplies
    logic        f1_reg, f2_reg, done_reg;
    logic [31:0] fr1_reg, fr2_reg;
    logic        z1_reg, z2_reg;
    logic        nx1_reg, ny1_reg, nx2_reg, ny2_reg;
    logic [35:0] vx_reg, vy_reg;
    logic [63:0] wl_reg, wh_reg;
    logic [67:0] mxl_reg, mxh_reg, myl_reg, myh_reg;
    logic [31:0] wt_reg;
    result_t     result_reg;
    logic [65:0] uxg, uyg;
    logic [96:0] wsum;
    logic [99:0] gxsum, gysum;
    logic [31:0] gx_mag, gy_mag;
    logic [31:0] limx, limy;

    assign uxg   = 66'(ux) * 66'(dv_side.gmag);
    assign uyg   = 66'(uy) * 66'(dv_side.gmag);
    assign wsum  = {1'b0, wh_reg, 32'd0} + 97'(wl_reg);
    assign gxsum = {mxh_reg, 32'd0} + 100'(mxl_reg);
    assign gysum = {myh_reg, 32'd0} + 100'(myl_reg);
    assign limx  = nx2_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign limy  = ny2_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign gx_mag = (gxsum[99:46] > 54'(limx)) ? limx : gxsum[77:46];
    assign gy_mag = (gysum[99:46] > 54'(limy)) ? limy : gysum[77:46];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_reg   <= 1'b0;
            f2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            f1_reg   <= dv_valid;
            f2_reg   <= f1_reg;
            done_reg <= f2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        vx_reg  <= uxg[65:30];
        vy_reg  <= uyg[65:30];
        wl_reg  <= 64'(ac_reg) * 64'(dv_side.p[31:0]);
        wh_reg  <= 64'(ac_reg) * 64'(dv_side.p[63:32]);
        nx1_reg <= dv_side.gneg ^ dv_side.xneg;
        ny1_reg <= dv_side.gneg ^ dv_side.yneg;
        z1_reg  <= (dv_r == 32'd0);
        fr1_reg <= dv_r;

        mxl_reg <= 68'(m_reg[31:0]) * 68'(vx_reg);
        mxh_reg <= 68'(m_reg[63:32]) * 68'(vx_reg);
        myl_reg <= 68'(m_reg[31:0]) * 68'(vy_reg);
        myh_reg <= 68'(m_reg[63:32]) * 68'(vy_reg);
        wt_reg  <= (wsum[96:60] > 37'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : wsum[91:60];
        nx2_reg <= nx1_reg;
        ny2_reg <= ny1_reg;
        z2_reg  <= z1_reg;
        fr2_reg <= fr1_reg;

        result_reg.dist_norm <= fr2_reg;
        result_reg.weight    <= wt_reg;
        result_reg.zero_dist <= z2_reg;
        if (z2_reg)
        begin
            result_reg.grad_x <= 32'sd0;
            result_reg.grad_y <= 32'sd0;
        end
        else
        begin
            result_reg.grad_x <= nx2_reg ? (32'd0 - gx_mag) : gx_mag;
            result_reg.grad_y <= ny2_reg ? (32'd0 - gy_mag) : gy_mag;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef NO_ASSERTIONS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LATENCY done)
        else $error("transaction did not complete after pipeline latency");

    a_zero_grad: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.zero_dist |-> result.grad_x == 0 && result.grad_y == 0)
        else $error("nonzero gradient at zero distance");

    a_weight_pos: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !result.weight[31])
        else $error("negative kernel weight");
`endif

endmodule
